// File: rtl/ugas_pkg.sv
// shared types and codes for the undirected graph adjacency store
package ugas_pkg;

  // fixed field widths of the transfer ports
  localparam int OP_W   = 3;
  localparam int NODE_W = 7;
  localparam int EDGE_W = 12;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD_NODE   = 3'd0;
  localparam logic [OP_W-1:0] OP_REM_NODE   = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_EDGE   = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_EDGE   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY_EDGE = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // take the input transfer
    logic add_node;    // hand out the next id
    logic read_a;      // read the row of node a
    logic query;       // latch the edge bit as the answer
    logic edge_a;      // rewrite row a, read row b, adjust edge count
    logic edge_b;      // rewrite row b
    logic walk_start;  // hold row a, read row zero
    logic walk_step;   // clear the column bit in one row, read the next
    logic walk_end;    // retire the removed node
    logic emit;        // load the result register
  } ugas_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            a_ok;       // node a names a present node
    logic            b_ok;       // node b names a present node
    logic            edge_hit;   // edge bit between a and b in the row just read
    logic            walk_last;  // walk is on its last row
    logic            out_free;   // result register can take a new result
  } ugas_stat_t;

endpackage

// File: rtl/ugas_mem.sv
// adjacency row memory with per-row valid bits, registered read
module ugas_mem import ugas_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_row
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  // storage array, read-first on a same-address access
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // row valid bits, a row never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

// File: rtl/ugas_ctrl.sv
// sequencer for the graph store operations
module ugas_ctrl import ugas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ugas_stat_t stat,
  output ugas_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EDGA   = 3'd2;
  localparam logic [2:0] S_EDGB   = 3'd3;
  localparam logic [2:0] S_RMROW  = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       change;

  // edge change needed for add of a missing edge or removal of an existing one
  assign change = ((stat.op == OP_ADD_EDGE) && !stat.edge_hit) ||
                  ((stat.op == OP_REM_EDGE) && stat.edge_hit);

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (stat.op)
          OP_ADD_NODE: begin
            cmd.add_node = 1'b1;
          end
          OP_REM_NODE: begin
            if (stat.a_ok) begin
              cmd.read_a = 1'b1;
              state_nxt  = S_RMROW;
            end
          end
          OP_ADD_EDGE, OP_REM_EDGE, OP_QUERY_EDGE: begin
            if (stat.a_ok && stat.b_ok) begin
              cmd.read_a = 1'b1;
              state_nxt  = S_EDGA;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_EDGA: begin
        state_nxt = S_DONE;
        if (stat.op == OP_QUERY_EDGE) begin
          cmd.query = 1'b1;
        end else if (change) begin
          cmd.edge_a = 1'b1;
          state_nxt  = S_EDGB;
        end
      end
      S_EDGB: begin
        cmd.edge_b = 1'b1;
        state_nxt  = S_DONE;
      end
      S_RMROW: begin
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          cmd.walk_end = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/ugas_dp.sv
// graph store datapath: node marks, counters, row memory and result register
module ugas_dp import ugas_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_op,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  ugas_cmd_t         cmd,
  output ugas_stat_t        stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [NODE_W-1:0] out_new_node,
  output logic              out_edge_present,
  output logic              out_changed,
  output logic              out_full_res,
  output logic [NODE_W-1:0] out_node_total,
  output logic [EDGE_W-1:0] out_edge_total
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int IDW = (AW + 1 > NODE_W) ? AW + 1 : NODE_W;

  logic [OP_W-1:0]      op_r;
  logic [NODE_W-1:0]    a_r;
  logic [NODE_W-1:0]    b_r;
  logic [MAX_NODES-1:0] present_r;
  logic [CW-1:0]        last_id_r;
  logic [CW-1:0]        count_r;
  logic [EDGE_W-1:0]    edges_r;
  logic [MAX_NODES-1:0] hold_r;
  logic [AW-1:0]        walk_r;
  logic [NODE_W-1:0]    res_new_r;
  logic                 res_hit_r;
  logic                 res_chg_r;
  logic                 res_full_r;
  logic                 out_valid_r;
  logic [NODE_W-1:0]    out_new_r;
  logic                 out_hit_r;
  logic                 out_chg_r;
  logic                 out_full_r;
  logic [NODE_W-1:0]    out_nodes_r;
  logic [EDGE_W-1:0]    out_edges_r;

  logic [IDW-1:0]       a_ext;
  logic [IDW-1:0]       b_ext;
  logic [AW-1:0]        ia;
  logic [AW-1:0]        ib;
  logic                 a_ok;
  logic                 b_ok;
  logic                 ids_full;
  logic                 set_val;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [MAX_NODES-1:0] wr_data;
  logic [MAX_NODES-1:0] rd_row;

  // id range check and presence lookup
  always_comb begin
    a_ext = IDW'(a_r);
    b_ext = IDW'(b_r);
    ia    = AW'(a_ext - IDW'(1));
    ib    = AW'(b_ext - IDW'(1));
    a_ok  = (a_ext != '0) && (a_ext <= IDW'(MAX_NODES)) && present_r[ia];
    b_ok  = (b_ext != '0) && (b_ext <= IDW'(MAX_NODES)) && present_r[ib];
  end

  assign ids_full = (last_id_r >= CW'(MAX_NODES));
  assign set_val  = (op_r == OP_ADD_EDGE);

  // memory read address
  always_comb begin
    rd_en   = cmd.read_a | cmd.edge_a | cmd.walk_start | cmd.walk_step;
    rd_addr = '0;
    if (cmd.read_a) begin
      rd_addr = ia;
    end else if (cmd.edge_a) begin
      rd_addr = ib;
    end else if (cmd.walk_step) begin
      rd_addr = walk_r + AW'(1);
    end
  end

  // memory write: edge bit in row a or b, or during the walk the column bit, or all of row a
  always_comb begin
    wr_en   = cmd.edge_a | cmd.edge_b | cmd.walk_step;
    wr_addr = ia;
    wr_data = rd_row;
    if (cmd.edge_a) begin
      wr_data[ib] = set_val;
    end else if (cmd.edge_b) begin
      wr_addr     = ib;
      wr_data[ia] = set_val;
    end else if (cmd.walk_step) begin
      wr_addr = walk_r;
      if (walk_r == ia) begin
        wr_data = '0;
      end else begin
        wr_data[ia] = 1'b0;
      end
    end
  end

  ugas_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (MAX_NODES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_row  (rd_row)
  );

  // status to the controller
  always_comb begin
    stat.op        = op_r;
    stat.a_ok      = a_ok;
    stat.b_ok      = b_ok;
    stat.edge_hit  = rd_row[ib];
    stat.walk_last = (walk_r == AW'(MAX_NODES - 1));
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // captured operation, held row and walk counter
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      a_r  <= in_node_a;
      b_r  <= in_node_b;
    end
    if (cmd.walk_start) begin
      hold_r <= rd_row;
      walk_r <= '0;
    end else if (cmd.walk_step) begin
      walk_r <= walk_r + AW'(1);
    end
  end

  // per-item result flags
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_new_r  <= '0;
      res_hit_r  <= 1'b0;
      res_chg_r  <= 1'b0;
      res_full_r <= 1'b0;
    end else begin
      if (cmd.add_node) begin
        if (ids_full) begin
          res_full_r <= 1'b1;
        end else begin
          res_new_r <= NODE_W'(last_id_r + CW'(1));
          res_chg_r <= 1'b1;
        end
      end
      if (cmd.query) begin
        res_hit_r <= rd_row[ib];
      end
      if (cmd.edge_a || cmd.walk_end) begin
        res_chg_r <= 1'b1;
      end
    end
  end

  // node marks and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      last_id_r <= '0;
      count_r   <= '0;
      edges_r   <= '0;
    end else begin
      if (cmd.add_node && !ids_full) begin
        present_r[AW'(last_id_r)] <= 1'b1;
        last_id_r                 <= last_id_r + CW'(1);
        count_r                   <= count_r + CW'(1);
      end
      if (cmd.walk_end) begin
        present_r[ia] <= 1'b0;
        count_r       <= count_r - CW'(1);
      end
      if (cmd.edge_a) begin
        edges_r <= set_val ? edges_r + EDGE_W'(1) : edges_r - EDGE_W'(1);
      end else if (cmd.walk_step && hold_r[walk_r]) begin
        edges_r <= edges_r - EDGE_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_new_r   <= res_new_r;
      out_hit_r   <= res_hit_r;
      out_chg_r   <= res_chg_r;
      out_full_r  <= res_full_r;
      out_nodes_r <= NODE_W'(count_r);
      out_edges_r <= edges_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_node     = out_new_r;
  assign out_edge_present = out_hit_r;
  assign out_changed      = out_chg_r;
  assign out_full_res     = out_full_r;
  assign out_node_total   = out_nodes_r;
  assign out_edge_total   = out_edges_r;

endmodule

// File: rtl/undirected_graph_adjacency_store.sv
// top level of the undirected graph adjacency store
//
// one operation per input transfer (in_op, in_node_a, in_node_b): add node,
// remove node, add edge, remove edge, query edge. every operation returns one
// result transfer with the id handed out, the query answer, the changed and
// full flags, and the node and edge totals after the operation.
// input is taken only while the sequencer is idle; a result waits in the
// output register while the next operation is accepted and worked on.
// from accept the sequencer decodes, runs the steps below and loads the result
// register in its done step, one row memory port pair doing all the work:
//   add node, unused operation or an operation naming an absent node: decode only
//   query edge, or an edge operation that finds nothing to change: read row a
//   edge change: read row a, rewrite row a and read row b, rewrite row b
//   remove node: read row a, then one row rewritten per cycle for the column
// the next transfer can be taken in the cycle after the result is loaded.
// a stalled result holds its register; the sequencer waits in its last step
// until the register is free, stalling the input meanwhile.
// reset clears node marks, counters and the row valid bits;
// no clearing pass runs, rows never written read as empty.
module undirected_graph_adjacency_store import ugas_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_new_node,
  output logic              out_edge_present,
  output logic              out_changed,
  output logic              out_full_res,
  output logic [NODE_W-1:0] out_node_total,
  output logic [EDGE_W-1:0] out_edge_total
);

  ugas_cmd_t  cmd;
  ugas_stat_t stat;

  // sequencer
  ugas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  ugas_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_new_node     (out_new_node),
    .out_edge_present (out_edge_present),
    .out_changed      (out_changed),
    .out_full_res     (out_full_res),
    .out_node_total   (out_node_total),
    .out_edge_total   (out_edge_total)
  );

endmodule

// File: rtl/ugas_checker.sv
// port-level checks for the graph store, bound to the top level
module ugas_checker import ugas_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] out_new_node,
  input logic              out_edge_present,
  input logic              out_changed,
  input logic              out_full_res,
  input logic [NODE_W-1:0] out_node_total,
  input logic [EDGE_W-1:0] out_edge_total
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_node) &&
    $stable(out_changed) && $stable(out_node_total) && $stable(out_edge_total))
    else $error("stalled result changed");

  // one operation at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an operation is in flight");

  // a failed add node hands out nothing and changes nothing
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> (out_new_node == '0) && !out_changed &&
    !out_edge_present)
    else $error("full result with an id or a change");

  // a query answer comes with no change and no id
  a_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_present |-> !out_changed && (out_new_node == '0))
    else $error("query answer mixed with a change");

  // a handed out id always marks a change
  a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_node != '0) |-> out_changed)
    else $error("new id without change");

endmodule

bind undirected_graph_adjacency_store ugas_checker u_ugas_checker (.*);

// File: tb/undirected_graph_adjacency_store_test.sv
// self-checking testbench for the undirected graph adjacency store
`timescale 1ns / 1ps

module undirected_graph_adjacency_store_test;
  import ugas_pkg::*;

  localparam int MAX_NODES   = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_OPS  = 790;
  localparam int DRAIN_AT    = 450;
  localparam int HOLD_AT     = 400;
  localparam int TAIL_CYCLES = 200;

  // one input transfer waiting to be driven
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              drain;  // hold this item until nothing is outstanding
  } graph_op_t;

  // one result transfer as predicted
  typedef struct packed {
    logic [NODE_W-1:0] new_node;
    logic              edge_present;
    logic              changed;
    logic              full_res;
    logic [NODE_W-1:0] node_total;
    logic [EDGE_W-1:0] edge_total;
  } graph_result_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_TOGGLE, RX_HEAVY} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = '0;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] out_new_node;
  logic              out_edge_present;
  logic              out_changed;
  logic              out_full_res;
  logic [NODE_W-1:0] out_node_total;
  logic [EDGE_W-1:0] out_edge_total;

  undirected_graph_adjacency_store #(.MAX_NODES(MAX_NODES)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_node     (out_new_node),
    .out_edge_present (out_edge_present),
    .out_changed      (out_changed),
    .out_full_res     (out_full_res),
    .out_node_total   (out_node_total),
    .out_edge_total   (out_edge_total)
  );

  // stimulus and expected results
  graph_op_t     pending_ops[$];
  graph_result_t expected_results[$];
  graph_op_t     next_op;
  int            pending_total = 0;
  int            items_sent = 0;
  int            results_seen = 0;
  int            errors = 0;
  int            cycles = 0;

  // graph mirror used to predict results
  logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
  logic [MAX_NODES-1:0] node_marks = '0;
  int                   ids_used = 0;
  int                   nodes_live = 0;
  int                   edges_live = 0;
  int                   removals_seen = 0;
  int                   query_hits = 0;
  int                   full_seen = 0;

  // generator view of which ids are live, to aim edge operations
  logic [MAX_NODES-1:0] gen_live = '0;
  int                   gen_ids = 0;

  // sender burst and receiver pattern state
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // reset, once
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit node_live(logic [NODE_W-1:0] id);
    int i;
    i = int'(id);
    if (i < 1 || i > MAX_NODES) return 1'b0;
    return node_marks[i-1];
  endfunction

  // apply one operation to the mirror and queue its result
  task automatic graph_model_step(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                                  logic [NODE_W-1:0] b);
    graph_result_t r;
    int ia;
    int ib;
    r  = '0;
    ia = int'(a) - 1;
    ib = int'(b) - 1;
    case (op)
      OP_ADD_NODE: begin
        if (ids_used >= MAX_NODES) begin
          r.full_res = 1'b1;
          full_seen++;
        end else begin
          ids_used++;
          node_marks[ids_used-1] = 1'b1;
          nodes_live++;
          r.new_node = NODE_W'(ids_used);
          r.changed  = 1'b1;
        end
      end
      OP_REM_NODE: begin
        if (node_live(a)) begin
          // clear row and column, one edge per distinct neighbor
          for (int j = 0; j < MAX_NODES; j++) begin
            if (adj_rows[ia][j]) begin
              adj_rows[ia][j] = 1'b0;
              adj_rows[j][ia] = 1'b0;
              edges_live--;
            end
          end
          node_marks[ia] = 1'b0;
          nodes_live--;
          r.changed = 1'b1;
          removals_seen++;
        end
      end
      OP_ADD_EDGE: begin
        if (node_live(a) && node_live(b) && !adj_rows[ia][ib]) begin
          adj_rows[ia][ib] = 1'b1;
          adj_rows[ib][ia] = 1'b1;
          edges_live++;
          r.changed = 1'b1;
        end
      end
      OP_REM_EDGE: begin
        if (node_live(a) && node_live(b) && adj_rows[ia][ib]) begin
          adj_rows[ia][ib] = 1'b0;
          adj_rows[ib][ia] = 1'b0;
          edges_live--;
          r.changed = 1'b1;
        end
      end
      OP_QUERY_EDGE: begin
        if (node_live(a) && node_live(b) && adj_rows[ia][ib]) begin
          r.edge_present = 1'b1;
          query_hits++;
        end
      end
      default: ;
    endcase
    r.node_total = NODE_W'(nodes_live);
    r.edge_total = EDGE_W'(edges_live);
    expected_results.push_back(r);
  endtask

  // queue one transfer and track which ids it leaves live
  task automatic queue_op(logic [OP_W-1:0] op, logic [NODE_W-1:0] a,
                          logic [NODE_W-1:0] b, logic drain);
    pending_ops.push_back('{op, a, b, drain});
    if (op == OP_ADD_NODE && gen_ids < MAX_NODES) begin
      gen_ids++;
      gen_live[gen_ids-1] = 1'b1;
    end else if (op == OP_REM_NODE && a >= 1 && a <= MAX_NODES) begin
      gen_live[a-1] = 1'b0;
    end
  endtask

  function automatic logic [NODE_W-1:0] pick_live_node();
    int ids[$];
    for (int i = 0; i < MAX_NODES; i++)
      if (gen_live[i]) ids.push_back(i + 1);
    if (ids.size() == 0) return NODE_W'($urandom_range(1, 127));
    return NODE_W'(ids[$urandom_range(0, ids.size() - 1)]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    errors++;
  endtask

  // stimulus: directed corner cases, then mostly well-formed random traffic
  initial begin
    int r;
    int good;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [NODE_W-1:0] last_a;
    logic [NODE_W-1:0] last_b;
    logic drain;

    for (int i = 0; i < MAX_NODES; i++) adj_rows[i] = '0;

    queue_op(OP_ADD_NODE,   7'd0,   7'd0,   1'b0);
    queue_op(OP_ADD_NODE,   7'd0,   7'd0,   1'b0);
    queue_op(OP_ADD_NODE,   7'd127, 7'd127, 1'b0);
    // self-loop counts once
    queue_op(OP_ADD_EDGE,   7'd1,   7'd1,   1'b0);
    queue_op(OP_ADD_EDGE,   7'd1,   7'd2,   1'b0);
    // edge already there
    queue_op(OP_ADD_EDGE,   7'd2,   7'd1,   1'b0);
    queue_op(OP_ADD_EDGE,   7'd2,   7'd3,   1'b0);
    queue_op(OP_QUERY_EDGE, 7'd2,   7'd1,   1'b0);
    queue_op(OP_QUERY_EDGE, 7'd1,   7'd3,   1'b0);
    // ids out of range, then removal of an existing edge
    queue_op(OP_QUERY_EDGE, 7'd0,   7'd1,   1'b0);
    queue_op(OP_ADD_EDGE,   7'd1,   7'd127, 1'b0);
    queue_op(OP_ADD_EDGE,   7'd65,  7'd1,   1'b0);
    queue_op(OP_REM_EDGE,   7'd3,   7'd2,   1'b0);
    // edge missing
    queue_op(OP_REM_EDGE,   7'd3,   7'd2,   1'b0);
    // node with a self-loop and a neighbor
    queue_op(OP_REM_NODE,   7'd1,   7'd0,   1'b0);
    // absent nodes, then a self-loop on a present node
    queue_op(OP_REM_NODE,   7'd1,   7'd0,   1'b0);
    queue_op(OP_ADD_EDGE,   7'd1,   7'd2,   1'b0);
    queue_op(OP_QUERY_EDGE, 7'd1,   7'd1,   1'b0);
    queue_op(OP_REM_NODE,   7'd0,   7'd0,   1'b0);
    queue_op(OP_REM_NODE,   7'd127, 7'd0,   1'b0);
    queue_op(OP_ADD_EDGE,   7'd64,  7'd64,  1'b0);
    queue_op(OP_ADD_EDGE,   7'd2,   7'd2,   1'b0);
    // unused op codes
    queue_op(3'd5,          7'd127, 7'd127, 1'b0);
    queue_op(3'd6,          7'd64,  7'd64,  1'b0);
    queue_op(3'd7,          7'd0,   7'd0,   1'b0);

    good   = 0;
    last_a = 7'd2;
    last_b = 7'd3;
    while (good < RANDOM_OPS) begin
      r     = $urandom_range(0, 99);
      drain = (good == DRAIN_AT);
      if (r < 10 && !drain) begin
        // noise: any op code, any id
        queue_op(OP_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 127)),
                 NODE_W'($urandom_range(0, 127)), 1'b0);
      end else begin
        good++;
        a = pick_live_node();
        b = ($urandom_range(0, 19) == 0) ? a : pick_live_node();
        if ((($countones(gen_live) < 3) && gen_ids < MAX_NODES) || r < 20) begin
          queue_op(OP_ADD_NODE, NODE_W'($urandom_range(0, 127)),
                   NODE_W'($urandom_range(0, 127)), drain);
        end else if (r < 24) begin
          queue_op(OP_REM_NODE, a, NODE_W'($urandom_range(0, 127)), drain);
        end else if (r < 60) begin
          queue_op(OP_ADD_EDGE, a, b, drain);
          last_a = a;
          last_b = b;
        end else if (r < 78) begin
          // half the removals aim at the edge added last
          if ($urandom_range(0, 1) == 0) queue_op(OP_REM_EDGE, last_b, last_a, drain);
          else queue_op(OP_REM_EDGE, a, b, drain);
        end else begin
          queue_op(OP_QUERY_EDGE, a, b, drain);
        end
      end
    end
    pending_total = pending_ops.size();

    // wait for every transfer, every result, then a quiet tail
    while (items_sent < pending_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d operations with %0d results: %0d node removals, %0d query hits,",
             items_sent, results_seen, removals_seen, query_hits);
    $display("%0d adds refused after all ids were used, %0d cycles", full_seen, cycles);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver: bursts with random gaps, one pause until all results are back
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        graph_model_step(in_op, in_node_a, in_node_b);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain && expected_results.size() != 0)) begin
          next_op = pending_ops.pop_front();
          in_valid  <= 1'b1;
          in_op     <= next_op.op;
          in_node_a <= next_op.node_a;
          in_node_b <= next_op.node_b;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, then pick the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, none", 32'd0, 32'd0);
        end else begin
          graph_result_t want;
          want = expected_results.pop_front();
          if (out_new_node !== want.new_node)
            report_mismatch("new_node", 32'(out_new_node), 32'(want.new_node));
          if (out_edge_present !== want.edge_present)
            report_mismatch("edge_present", 32'(out_edge_present),
                            32'(want.edge_present));
          if (out_changed !== want.changed)
            report_mismatch("changed", 32'(out_changed), 32'(want.changed));
          if (out_full_res !== want.full_res)
            report_mismatch("full_res", 32'(out_full_res), 32'(want.full_res));
          if (out_node_total !== want.node_total)
            report_mismatch("node_total", 32'(out_node_total), 32'(want.node_total));
          if (out_edge_total !== want.edge_total)
            report_mismatch("edge_total", 32'(out_edge_total), 32'(want.edge_total));
        end
        results_seen++;
      end

      // one long hold-off so the block backs up into its input
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 99) < 30);
          RX_TOGGLE: out_stall <= ~out_stall;
          RX_HEAVY:  out_stall <= ($urandom_range(0, 99) < 75);
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
